// ----- rtl/scan_point_clustering_macros.svh -----
// Assertion macros for the scan point clustering block.
// Used by the checker file; needs nothing else.
`ifndef SCAN_POINT_CLUSTERING_MACROS_SVH
`define SCAN_POINT_CLUSTERING_MACROS_SVH

// Generic clocked assertion with asynchronous active-low reset disable
`define SCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair
`define SCP_ASSERT_CLK(lbl, prop, msg) \
  `SCP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/scp_pkg.sv -----
// Package for the scan point clustering block: sequencer states,
// register indexes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package scp_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int REG_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_HALF_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_HALF_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_DIST    = 2'd2;

  localparam logic [REG_W-1:0] RST_FIELD_HALF_X = 15'd1350;
  localparam logic [REG_W-1:0] RST_FIELD_HALF_Y = 15'd1500;
  localparam logic [REG_W-1:0] RST_BREAK_DIST   = 15'd35;

  // Output count fields
  localparam int CNT_OUT_W = 12;
  localparam logic [CNT_OUT_W-1:0] TOTAL_MAX = 12'hFFF;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQL,
    ST_TEST,
    ST_DIV,
    ST_EMIT,
    ST_JOIN,
    ST_FLUSH,
    ST_MARK
  } scp_state_e;

endpackage

// ----- rtl/scp_if.sv -----
// Valid/ready channel interfaces for scan points and clustering results.
// Depends on scp_pkg for the count field width.
`timescale 1ns / 1ps

interface scp_point_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic                end_of_scan;

  modport source (output valid, point_x, point_y, point_z, end_of_scan, input ready);
  modport sink   (input valid, point_x, point_y, point_z, end_of_scan, output ready);
endinterface

interface scp_result_if #(parameter int W = 16) ();
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [W-1:0]                centroid_x;
  logic signed [W-1:0]                centroid_y;
  logic        [scp_pkg::CNT_OUT_W-1:0] point_count;
  logic signed [W-1:0]                first_x;
  logic signed [W-1:0]                first_y;
  logic signed [W-1:0]                first_z;
  logic        [scp_pkg::CNT_OUT_W-1:0] cluster_total;
  logic                               last;

  modport source (output valid, kind, centroid_x, centroid_y, point_count, first_x,
                  first_y, first_z, cluster_total, last, input ready);
  modport sink   (input valid, kind, centroid_x, centroid_y, point_count, first_x,
                  first_y, first_z, cluster_total, last, output ready);
endinterface

// ----- rtl/scan_point_clustering.sv -----
// Sequence: a skipped point returns to idle after PREP, the first point of a cluster joins
//   directly, other points run a distance test through one shared squarer; each cluster
//   report adds the bit-serial centroid divider plus any output stall; end of scan adds
//   the FLUSH and MARK states. One point at a time: a new point is taken only in IDLE.
// Reset: registers take 1350/1500/35, cluster state and totals clear at once.
`timescale 1ns / 1ps

// Top level: breakpoint clustering of scan points; uses scp_pkg and scp_if.
module scan_point_clustering #(
  parameter int COORD_BITS         = 16,
  parameter int MAX_CLUSTER_POINTS = 4095
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [scp_pkg::REG_W-1:0]     cfg_data_i,
  scp_point_if.sink                     pt_i,
  scp_result_if.source                  res_o
);

  localparam int C    = COORD_BITS;
  localparam int CW   = $clog2(MAX_CLUSTER_POINTS + 1);
  localparam int SW   = C + CW;
  localparam int MW   = (C > scp_pkg::REG_W) ? C : scp_pkg::REG_W;
  localparam int PW   = 2 * MW;
  localparam int ACCW = PW + 2;
  localparam int STW  = $clog2(C);
  localparam int OCW  = scp_pkg::CNT_OUT_W;

  scp_pkg::scp_state_e state_q, state_d;

  // Configuration
  logic [scp_pkg::REG_W-1:0] half_x_q, half_y_q, brk_q;

  // Captured point
  logic signed [C-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic                eos_q;

  // Distance test
  logic [C-1:0]    adx_q, ady_q, adz_q;
  logic [MW-1:0]   mul_op;
  logic [PW-1:0]   prod_c, prod_q;
  logic [ACCW-1:0] acc_q;

  // Cluster state
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic [CW-1:0]        cnt_q;
  logic signed [C-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic signed [C-1:0]  head_x_q, head_y_q, head_z_q;
  logic [OCW-1:0]       total_q;

  // Divider
  logic [CW-1:0]        rem_q;
  logic [C-1:0]         dq_q;
  logic [STW-1:0]       step_q;
  logic                 div_sel_q;
  logic                 div_neg_q;
  logic signed [C-1:0]  qx_q, qy_q;
  logic                 flush_q;

  // Output register
  logic                 out_valid_q;
  logic                 out_kind_q, out_last_q;
  logic signed [C-1:0]  out_cx_q, out_cy_q, out_fx_q, out_fy_q, out_fz_q;
  logic [OCW-1:0]       out_cnt_q, out_total_q;

  // Control strobes
  logic pt_ready, pt_take, out_free;
  logic clr_cluster, join_pt, div_init, load_report, load_marker;

  // Status
  logic use_c, brk_c, cnt_ge2, cnt_open, div_last;
  logic [C-1:0] ax_c, ay_c;

  // ---------------------------------------------------------------------------
  // Point screening
  assign ax_c = pt_x_q[C-1] ? C'(-pt_x_q) : C'(pt_x_q);
  assign ay_c = pt_y_q[C-1] ? C'(-pt_y_q) : C'(pt_y_q);

  assign use_c = ((pt_x_q != '0) || (pt_y_q != '0) || (pt_z_q != '0)) &&
                 (MW'(ax_c) <= MW'(half_x_q)) && (MW'(ay_c) <= MW'(half_y_q));

  assign cnt_open = (cnt_q != '0);
  assign cnt_ge2  = (cnt_q >= CW'(2));
  assign brk_c    = (acc_q > ACCW'(prod_q));
  assign div_last = (state_q == scp_pkg::ST_DIV) && (step_q == STW'(C - 1));
  assign out_free = !out_valid_q || res_o.ready;
  assign pt_take  = pt_i.valid && pt_ready;

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scp_pkg::ST_IDLE:  if (pt_i.valid) state_d = scp_pkg::ST_PREP;
      scp_pkg::ST_PREP: begin
        if (use_c && cnt_open) state_d = scp_pkg::ST_SQX;
        else if (use_c)        state_d = scp_pkg::ST_JOIN;
        else if (eos_q)        state_d = scp_pkg::ST_FLUSH;
        else                   state_d = scp_pkg::ST_IDLE;
      end
      scp_pkg::ST_SQX:   state_d = scp_pkg::ST_SQY;
      scp_pkg::ST_SQY:   state_d = scp_pkg::ST_SQZ;
      scp_pkg::ST_SQZ:   state_d = scp_pkg::ST_SQL;
      scp_pkg::ST_SQL:   state_d = scp_pkg::ST_TEST;
      scp_pkg::ST_TEST:  state_d = (brk_c && cnt_ge2) ? scp_pkg::ST_DIV : scp_pkg::ST_JOIN;
      scp_pkg::ST_DIV:   if (div_last && div_sel_q) state_d = scp_pkg::ST_EMIT;
      scp_pkg::ST_EMIT:  if (out_free) state_d = flush_q ? scp_pkg::ST_MARK : scp_pkg::ST_JOIN;
      scp_pkg::ST_JOIN:  state_d = eos_q ? scp_pkg::ST_FLUSH : scp_pkg::ST_IDLE;
      scp_pkg::ST_FLUSH: state_d = cnt_ge2 ? scp_pkg::ST_DIV : scp_pkg::ST_MARK;
      scp_pkg::ST_MARK:  if (out_free) state_d = scp_pkg::ST_IDLE;
      default:           state_d = scp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pt_ready    = 1'b0;
    clr_cluster = 1'b0;
    join_pt     = 1'b0;
    div_init    = 1'b0;
    load_report = 1'b0;
    load_marker = 1'b0;
    mul_op      = '0;
    unique case (state_q)
      scp_pkg::ST_IDLE:  pt_ready = 1'b1;
      scp_pkg::ST_SQX:   mul_op = MW'(adx_q);
      scp_pkg::ST_SQY:   mul_op = MW'(ady_q);
      scp_pkg::ST_SQZ:   mul_op = MW'(adz_q);
      scp_pkg::ST_SQL:   mul_op = MW'(brk_q);
      scp_pkg::ST_TEST: begin
        // a lone point before the gap is simply dropped
        if (brk_c && cnt_ge2) div_init = 1'b1;
        else if (brk_c)       clr_cluster = 1'b1;
      end
      scp_pkg::ST_EMIT: begin
        load_report = out_free;
        clr_cluster = out_free;
      end
      scp_pkg::ST_JOIN:  join_pt = 1'b1;
      scp_pkg::ST_FLUSH: begin
        if (cnt_ge2) div_init = 1'b1;
        else         clr_cluster = 1'b1;
      end
      scp_pkg::ST_MARK: begin
        load_marker = out_free;
        clr_cluster = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared squarer
  assign prod_c = PW'(mul_op) * PW'(mul_op);

  // ---------------------------------------------------------------------------
  // Bit-serial divider: |sum| / count, one quotient bit per cycle
  logic signed [SW-1:0] div_src;
  logic [SW-1:0]        div_abs;
  logic [CW:0]          div_tr;
  logic                 div_ge;
  logic [CW:0]          div_diff;
  logic [C-1:0]         q_mag;
  logic signed [C-1:0]  q_res;

  assign div_src  = (state_q == scp_pkg::ST_DIV) ? sum_y_q : sum_x_q;
  assign div_abs  = div_src[SW-1] ? SW'(-div_src) : SW'(div_src);
  assign div_tr   = {rem_q, dq_q[C-1]};
  assign div_ge   = (div_tr >= (CW + 1)'(cnt_q));
  assign div_diff = div_tr - (CW + 1)'(cnt_q);
  assign q_mag    = {dq_q[C-2:0], div_ge};
  assign q_res    = div_neg_q ? C'(-q_mag) : C'(q_mag);

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scp_pkg::ST_IDLE;
      half_x_q    <= scp_pkg::RST_FIELD_HALF_X;
      half_y_q    <= scp_pkg::RST_FIELD_HALF_Y;
      brk_q       <= scp_pkg::RST_BREAK_DIST;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      cnt_q       <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      head_x_q    <= '0;
      head_y_q    <= '0;
      head_z_q    <= '0;
      total_q     <= '0;
      step_q      <= '0;
      div_sel_q   <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes, index beyond the list ignored
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          scp_pkg::REG_FIELD_HALF_X: half_x_q <= cfg_data_i;
          scp_pkg::REG_FIELD_HALF_Y: half_y_q <= cfg_data_i;
          scp_pkg::REG_BREAK_DIST:   brk_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // cluster bookkeeping
      if (clr_cluster) begin
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        cnt_q    <= '0;
        prev_x_q <= '0;
        prev_y_q <= '0;
        prev_z_q <= '0;
        head_x_q <= '0;
        head_y_q <= '0;
        head_z_q <= '0;
      end else if (join_pt) begin
        if (!cnt_open) begin
          head_x_q <= pt_x_q;
          head_y_q <= pt_y_q;
          head_z_q <= pt_z_q;
        end
        // saturated count freezes the sums too
        if (cnt_q < CW'(MAX_CLUSTER_POINTS)) begin
          cnt_q   <= cnt_q + CW'(1);
          sum_x_q <= sum_x_q + SW'(pt_x_q);
          sum_y_q <= sum_y_q + SW'(pt_y_q);
        end
        prev_x_q <= pt_x_q;
        prev_y_q <= pt_y_q;
        prev_z_q <= pt_z_q;
      end

      if (load_marker)                             total_q <= '0;
      else if (load_report && total_q != scp_pkg::TOTAL_MAX) total_q <= total_q + OCW'(1);

      // divider sequencing: x first, then y
      if (div_init) begin
        step_q    <= '0;
        div_sel_q <= 1'b0;
        flush_q   <= (state_q == scp_pkg::ST_FLUSH);
      end else if (div_last) begin
        step_q    <= '0;
        div_sel_q <= 1'b1;
      end else if (state_q == scp_pkg::ST_DIV) begin
        step_q    <= step_q + STW'(1);
      end

      if (load_report || load_marker) out_valid_q <= 1'b1;
      else if (res_o.ready)           out_valid_q <= 1'b0;
    end
  end

  // |a - b| of two coordinates, fits COORD_BITS unsigned
  function automatic logic [C-1:0] abs_gap(input logic signed [C-1:0] a,
                                           input logic signed [C-1:0] b);
    logic signed [C:0] d;
    logic [C:0]        m;
    d = (C + 1)'(a) - (C + 1)'(b);
    m = d[C] ? (C + 1)'(-d) : (C + 1)'(d);
    return m[C-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pt_take) begin
      pt_x_q <= pt_i.point_x;
      pt_y_q <= pt_i.point_y;
      pt_z_q <= pt_i.point_z;
      eos_q  <= pt_i.end_of_scan;
    end

    // absolute gaps to the last cluster point
    if (state_q == scp_pkg::ST_PREP) begin
      adx_q <= abs_gap(pt_x_q, prev_x_q);
      ady_q <= abs_gap(pt_y_q, prev_y_q);
      adz_q <= abs_gap(pt_z_q, prev_z_q);
    end

    // squared distance accumulate, limit squared lands in prod_q
    prod_q <= prod_c;
    if (state_q == scp_pkg::ST_SQY)
      acc_q <= ACCW'(prod_q);
    else if (state_q == scp_pkg::ST_SQZ || state_q == scp_pkg::ST_SQL)
      acc_q <= acc_q + ACCW'(prod_q);

    // divider load or step
    if (div_init || (div_last && !div_sel_q)) begin
      rem_q     <= div_abs[SW-1:C];
      dq_q      <= div_abs[C-1:0];
      div_neg_q <= div_src[SW-1];
    end else if (state_q == scp_pkg::ST_DIV) begin
      rem_q <= div_ge ? div_diff[CW-1:0] : div_tr[CW-1:0];
      dq_q  <= q_mag;
    end
    if (div_last && !div_sel_q) qx_q <= q_res;
    if (div_last &&  div_sel_q) qy_q <= q_res;

    // result register
    if (load_report) begin
      out_kind_q  <= scp_pkg::KIND_REPORT;
      out_cx_q    <= qx_q;
      out_cy_q    <= qy_q;
      out_cnt_q   <= OCW'(cnt_q);
      out_fx_q    <= head_x_q;
      out_fy_q    <= head_y_q;
      out_fz_q    <= head_z_q;
      out_total_q <= '0;
      out_last_q  <= !flush_q && !eos_q;
    end else if (load_marker) begin
      out_kind_q  <= scp_pkg::KIND_MARKER;
      out_cx_q    <= '0;
      out_cy_q    <= '0;
      out_cnt_q   <= '0;
      out_fx_q    <= '0;
      out_fy_q    <= '0;
      out_fz_q    <= '0;
      out_total_q <= total_q;
      out_last_q  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  assign pt_i.ready          = pt_ready;
  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_kind_q;
  assign res_o.centroid_x    = out_cx_q;
  assign res_o.centroid_y    = out_cy_q;
  assign res_o.point_count   = out_cnt_q;
  assign res_o.first_x       = out_fx_q;
  assign res_o.first_y       = out_fy_q;
  assign res_o.first_z       = out_fz_q;
  assign res_o.cluster_total = out_total_q;
  assign res_o.last          = out_last_q;

endmodule

// ----- rtl/scp_checker.sv -----
// Port-level checker for scan_point_clustering, with its bind statement.
// Depends on scp_pkg and scan_point_clustering_macros.svh.
`timescale 1ns / 1ps
`include "scan_point_clustering_macros.svh"

module scp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_kind_i,
  input logic                          out_last_i,
  input logic [scp_pkg::CNT_OUT_W-1:0] out_total_i
);

  // watched result fields as one word
  logic [scp_pkg::CNT_OUT_W+1:0] out_word;
  assign out_word = {out_kind_i, out_last_i, out_total_i};

  // one point at a time: busy right after a transfer
  `SCP_ASSERT_CLK(a_busy_after_take, in_valid_i && in_ready_i |=> !in_ready_i, "ready after transfer")

  // stalled result stays put
  `SCP_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word), "stalled result changed")

  // end marker closes the results of its point
  `SCP_ASSERT_CLK(a_marker_last, out_valid_i && out_kind_i == scp_pkg::KIND_MARKER |-> out_last_i, "marker without last")

  // cluster reports carry no total
  `SCP_ASSERT_CLK(a_report_total, out_valid_i && out_kind_i == scp_pkg::KIND_REPORT |-> out_total_i == '0, "report with total")

endmodule

bind scan_point_clustering scp_checker u_scp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.kind),
  .out_last_i  (res_o.last),
  .out_total_i (res_o.cluster_total)
);
